### design/route_request_retry_table_core_assert.svh
// Assertion macros for the route request retry table core.
// Depends on nothing; included by the top level only.
`ifndef ROUTE_REQUEST_RETRY_TABLE_CORE_ASSERT_SVH
`define ROUTE_REQUEST_RETRY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrt assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrt assertion failed");

`endif

### design/rrt_pkg.sv
// Shared types and codes of the route request retry table.
// No dependencies; used by every module of the block but the entry store.
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

   // Input functions
   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_CANCEL = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_SEND      = 3'd0;
   localparam logic [2:0] KIND_GAVE_UP   = 3'd1;
   localparam logic [2:0] KIND_RUNNING   = 3'd2;
   localparam logic [2:0] KIND_FULL      = 3'd3;
   localparam logic [2:0] KIND_CANCELLED = 3'd4;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd5;

   // Register indexes
   localparam int unsigned CSR_IDX_BITS  = 4;
   localparam int unsigned CSR_DATA_BITS = 24;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQUEST_PERIOD     = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_REQUEST_PERIOD = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_RETRANSMITS    = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_TTL          = 4'd3;

   // Register reset values
   localparam logic [23:0] RST_REQUEST_PERIOD     = 24'd500;
   localparam logic [23:0] RST_MAX_REQUEST_PERIOD = 24'd10000;
   localparam logic [7:0]  RST_MAX_RETRANSMITS    = 8'd16;
   localparam logic [7:0]  RST_START_TTL          = 8'd10;

   // Hop limit saturation and result count per item
   localparam logic [7:0] TTL_CAP = 8'd255;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned RES_BITS = 5;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] target_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] dest_addr;
      logic [7:0]  hop_limit;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [23:0] request_period;
      logic [23:0] max_request_period;
      logic [7:0]  max_retransmits;
      logic [7:0]  start_ttl;
   } cfg_type;

   // Result word from the sequencer to the output stage; fin closes the item
   typedef struct packed {
      logic        push;
      logic        fin;
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [7:0]  hop;
   } out_cmd_type;

endpackage

`default_nettype wire

### design/route_request_retry_table_core.sv
// Route request retry table: up to TABLE_ENTRIES targets under discovery,
// each with hop limit, backoff timeout, countdown and retry count.
//
// Channels: req (func, target_addr) in, rsp (kind, dest_addr, hop_limit,
// last) out, both valid/ready; csr writes one register per accepted word.
// Each item walks the entry store once, one entry per cycle while rsp is not
// stalled, through the single read port, so req_ready stays low from an
// accepted start, cancel or tick until the item is done: a new item enters
// only after the last one is through. An unused func is taken and dropped
// while idle. A start or cancel gives one word, at the end of the walk; a tick
// gives one word per expired entry, in index order, at most 16, and none if
// nothing expired. The final word of an item has last. One result word is
// held back until the next one or the end of the item is known, so each word
// leaves with the push of the next word or at the close of its item, not
// with the entry that caused it.
// A stalled rsp stalls the walk at the entry that wants to emit; no word is
// lost. req_ready is high only between items.
// Reset clears the valid bits and the registers to their defaults; the
// entry store itself needs no clearing, as entries are used only while valid.
`timescale 1ns / 1ps
`default_nettype none

`include "route_request_retry_table_core_assert.svh"

module route_request_retry_table_core #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned TIMER_BITS    = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire rrt_pkg::req_type                  req_word,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output rrt_pkg::rsp_type                       rsp_word,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rrt_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [rrt_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int unsigned IDX_BITS   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned ENTRY_BITS = 48 + 2 * TIMER_BITS;

   rrt_pkg::cfg_type      cfg;
   rrt_pkg::out_cmd_type  cmd;
   logic                  cmd_ready;
   logic                  pend_valid;
   logic                  mem_wr_en, mem_rd_en;
   logic [IDX_BITS-1:0]   mem_wr_idx, mem_rd_idx;
   logic [ENTRY_BITS-1:0] mem_wr_data, mem_rd_data;
   logic                  req_take_known;
   logic                  rsp_not_send;

   rrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rrt_table_mem #(
      .DEPTH     (TABLE_ENTRIES),
      .IDX_BITS  (IDX_BITS),
      .DATA_BITS (ENTRY_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_idx  (mem_wr_idx),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rd_data)
   );

   rrt_seq #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TIMER_BITS    (TIMER_BITS),
      .IDX_BITS      (IDX_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .cmd         (cmd),
      .cmd_ready   (cmd_ready),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_idx  (mem_wr_idx),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_idx  (mem_rd_idx),
      .mem_rd_data (mem_rd_data)
   );

   rrt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .pend_valid (pend_valid),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   // Terms used by the checks below
   assign req_take_known = req_valid && req_ready &&
                           (req_word.func inside {rrt_pkg::FUNC_START, rrt_pkg::FUNC_CANCEL,
                                                  rrt_pkg::FUNC_TICK});
   assign rsp_not_send   = rsp_valid && (rsp_word.kind != rrt_pkg::KIND_SEND);

   // An accepted start, cancel or tick keeps the block busy for the next cycle
   `RRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take_known, !req_ready)
   // No word of the previous item is still held back when a new one can enter
   `RRT_ASSERT_IMPL(a_flushed_when_idle, clock, reset, req_ready, !pend_valid)
   // Only send words carry a hop limit
   `RRT_ASSERT_IMPL(a_hop_only_on_send, clock, reset, rsp_not_send, rsp_word.hop_limit == 8'd0)

endmodule

`default_nettype wire

### design/rrt_csr.sv
// Configuration registers of the route request retry table.
// Depends on rrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrt_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rrt_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [rrt_pkg::CSR_DATA_BITS-1:0] csr_data,
   output rrt_pkg::cfg_type                       cfg
);

   rrt_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rrt_pkg::CSR_REQUEST_PERIOD:     cfg_in.request_period     = csr_data[23:0];
            rrt_pkg::CSR_MAX_REQUEST_PERIOD: cfg_in.max_request_period = csr_data[23:0];
            rrt_pkg::CSR_MAX_RETRANSMITS:    cfg_in.max_retransmits    = csr_data[7:0];
            rrt_pkg::CSR_START_TTL:          cfg_in.start_ttl          = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.request_period     <= rrt_pkg::RST_REQUEST_PERIOD;
         cfg_ff.max_request_period <= rrt_pkg::RST_MAX_REQUEST_PERIOD;
         cfg_ff.max_retransmits    <= rrt_pkg::RST_MAX_RETRANSMITS;
         cfg_ff.start_ttl          <= rrt_pkg::RST_START_TTL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### design/rrt_table_mem.sv
// Entry store of the route request retry table: one write, one read port.
// Read data is registered and holds while no read is issued.
`timescale 1ns / 1ps
`default_nettype none

module rrt_table_mem #(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned IDX_BITS  = 4,
   parameter int unsigned DATA_BITS = 96
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [IDX_BITS-1:0]  wr_idx,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [IDX_BITS-1:0]  rd_idx,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] table_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_idx] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_idx];
      end
   end

endmodule

`default_nettype wire

### design/rrt_out.sv
// Output stage: holds one result word back until the next one or the end of
// the item is known, so that the final word carries last. Depends on rrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrt_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrt_pkg::out_cmd_type cmd,
   output logic                      cmd_ready,
   output logic                      pend_valid,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rrt_pkg::rsp_type          rsp_word
);

   logic             rsp_valid_ff, rsp_valid_in;
   rrt_pkg::rsp_type rsp_ff, rsp_in;
   logic             pend_valid_ff, pend_valid_in;
   rrt_pkg::rsp_type pend_ff, pend_in;
   logic             rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign cmd_ready  = !pend_valid_ff || rsp_free;
   assign pend_valid = pend_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // A new word pushes the held one out; the end of item flushes it with last
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (cmd.push && cmd_ready) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_in.last  = 1'b0;
         end
         pend_valid_in     = 1'b1;
         pend_in.kind      = cmd.kind;
         pend_in.dest_addr = cmd.addr;
         pend_in.hop_limit = cmd.hop;
         pend_in.last      = 1'b0;
      end else if (cmd.fin && cmd_ready && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

### design/rrt_seq.sv
// Sequencer of the route request retry table: walks the store once per item,
// reads one entry a cycle unless stalled, writes back on ticks. Uses rrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrt_seq #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned TIMER_BITS    = 24,
   parameter int unsigned IDX_BITS      = 4,
   parameter int unsigned ENTRY_BITS    = 96
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rrt_pkg::cfg_type      cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire rrt_pkg::req_type      req_word,
   output rrt_pkg::out_cmd_type       cmd,
   input  wire logic                  cmd_ready,
   output logic                       mem_wr_en,
   output logic [IDX_BITS-1:0]        mem_wr_idx,
   output logic [ENTRY_BITS-1:0]      mem_wr_data,
   output logic                       mem_rd_en,
   output logic [IDX_BITS-1:0]        mem_rd_idx,
   input  wire logic [ENTRY_BITS-1:0] mem_rd_data
);

   localparam int unsigned CNT_BITS = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned CW = (TIMER_BITS + 1 > 24) ? TIMER_BITS + 1 : 24;
   localparam logic [TIMER_BITS-1:0] TIMER_ONE = {{(TIMER_BITS-1){1'b0}}, 1'b1};

   typedef struct packed {
      logic [31:0]           addr;
      logic [7:0]            ttl;
      logic [TIMER_BITS-1:0] timeout;
      logic [TIMER_BITS-1:0] remaining;
      logic [7:0]            retries;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_CLOSE  = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [1:0]                     func_ff, func_in;
   logic [31:0]                    addr_ff, addr_in;
   logic [CNT_BITS-1:0]            rd_cnt_ff, rd_cnt_in;
   logic                           ev_valid_ff, ev_valid_in;
   logic [IDX_BITS-1:0]            ev_idx_ff, ev_idx_in;
   logic                           found_ff, found_in;
   logic [IDX_BITS-1:0]            found_idx_ff, found_idx_in;
   logic                           free_ff, free_in;
   logic [IDX_BITS-1:0]            free_idx_ff, free_idx_in;
   logic [rrt_pkg::RES_BITS-1:0]   res_cnt_ff, res_cnt_in;
   logic [TABLE_ENTRIES-1:0]       entry_valid_ff, entry_valid_in;

   entry_type             ent, wr_ent, new_ent;
   logic                  ev_live, expire, give_up, report, advance;
   logic [CW-1:0]         dbl_w, cap_w, mask_w, lim_w, rp_w;
   logic [TIMER_BITS-1:0] next_timeout, init_timeout;
   logic [7:0]            next_ttl;
   logic                  walk_done;

   assign ent         = entry_type'(mem_rd_data);
   assign mem_wr_data = ENTRY_BITS'(wr_ent);
   assign req_ready   = (state_ff == ST_IDLE);

   // Backoff arithmetic: doubled timeout capped by register and timer width
   assign dbl_w        = CW'({ent.timeout, 1'b0});
   assign cap_w        = CW'(cfg.max_request_period);
   assign mask_w       = CW'({TIMER_BITS{1'b1}});
   assign lim_w        = (cap_w < mask_w) ? cap_w : mask_w;
   assign next_timeout = (dbl_w > lim_w) ? lim_w[TIMER_BITS-1:0] : dbl_w[TIMER_BITS-1:0];
   assign next_ttl     = ent.ttl[7] ? rrt_pkg::TTL_CAP : {ent.ttl[6:0], 1'b0};
   assign rp_w         = CW'(cfg.request_period);
   assign init_timeout = rp_w[TIMER_BITS-1:0];

   // Evaluation of the entry whose read data is present
   assign ev_live   = ev_valid_ff && entry_valid_ff[ev_idx_ff];
   assign expire    = ev_live && (func_ff == rrt_pkg::FUNC_TICK) && !(ent.remaining > TIMER_ONE);
   assign give_up   = expire && (ent.retries >= cfg.max_retransmits);
   assign report    = expire && (res_cnt_ff < rrt_pkg::RES_BITS'(rrt_pkg::MAX_RESULTS));
   assign advance   = !report || cmd_ready;
   assign walk_done = (rd_cnt_ff == CNT_BITS'(TABLE_ENTRIES)) && !ev_valid_ff;

   // Entry written for a new start
   always_comb begin
      new_ent.addr      = addr_ff;
      new_ent.ttl       = cfg.start_ttl;
      new_ent.timeout   = init_timeout;
      new_ent.remaining = init_timeout;
      new_ent.retries   = 8'd0;
   end

   // Main sequencer
   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      addr_in        = addr_ff;
      rd_cnt_in      = rd_cnt_ff;
      ev_valid_in    = ev_valid_ff;
      ev_idx_in      = ev_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      res_cnt_in     = res_cnt_ff;
      entry_valid_in = entry_valid_ff;
      cmd            = '0;
      mem_wr_en      = 1'b0;
      mem_wr_idx     = ev_idx_ff;
      wr_ent         = ent;
      mem_rd_en      = 1'b0;
      mem_rd_idx     = rd_cnt_ff[IDX_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in    = req_word.func;
               addr_in    = req_word.target_addr;
               rd_cnt_in  = '0;
               ev_valid_in = 1'b0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               res_cnt_in = '0;
               if ((req_word.func == rrt_pkg::FUNC_START) ||
                   (req_word.func == rrt_pkg::FUNC_CANCEL) ||
                   (req_word.func == rrt_pkg::FUNC_TICK)) begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            cmd.push = report;
            cmd.kind = give_up ? rrt_pkg::KIND_GAVE_UP : rrt_pkg::KIND_SEND;
            cmd.addr = ent.addr;
            cmd.hop  = give_up ? 8'd0 : next_ttl;
            if (advance) begin
               // issue the next read while the current entry is evaluated
               if (rd_cnt_ff != CNT_BITS'(TABLE_ENTRIES)) begin
                  mem_rd_en   = 1'b1;
                  ev_valid_in = 1'b1;
                  ev_idx_in   = rd_cnt_ff[IDX_BITS-1:0];
                  rd_cnt_in   = rd_cnt_ff + 1'b1;
               end else begin
                  ev_valid_in = 1'b0;
               end
               if (report) begin
                  res_cnt_in = res_cnt_ff + 1'b1;
               end
               // search results for start and cancel
               if (ev_live && (ent.addr == addr_ff) && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = ev_idx_ff;
               end
               if (ev_valid_ff && !entry_valid_ff[ev_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = ev_idx_ff;
               end
               // countdown and backoff write-back
               if (ev_live && (func_ff == rrt_pkg::FUNC_TICK)) begin
                  if (!expire) begin
                     mem_wr_en        = 1'b1;
                     wr_ent.remaining = ent.remaining - TIMER_ONE;
                  end else if (give_up) begin
                     entry_valid_in[ev_idx_ff] = 1'b0;
                  end else begin
                     mem_wr_en        = 1'b1;
                     wr_ent.ttl       = next_ttl;
                     wr_ent.timeout   = next_timeout;
                     wr_ent.remaining = next_timeout;
                     wr_ent.retries   = ent.retries + 8'd1;
                  end
               end
            end
            if (walk_done) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            cmd.addr = addr_ff;
            if (func_ff == rrt_pkg::FUNC_START) begin
               cmd.push = 1'b1;
               if (found_ff) begin
                  cmd.kind = rrt_pkg::KIND_RUNNING;
               end else if (free_ff) begin
                  cmd.kind = rrt_pkg::KIND_SEND;
                  cmd.hop  = cfg.start_ttl;
               end else begin
                  cmd.kind = rrt_pkg::KIND_FULL;
               end
               if (cmd_ready) begin
                  if (!found_ff && free_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_idx  = free_idx_ff;
                     wr_ent      = new_ent;
                     entry_valid_in[free_idx_ff] = 1'b1;
                  end
                  state_in = ST_CLOSE;
               end
            end else if (func_ff == rrt_pkg::FUNC_CANCEL) begin
               cmd.push = 1'b1;
               cmd.kind = found_ff ? rrt_pkg::KIND_CANCELLED : rrt_pkg::KIND_NOT_FOUND;
               if (cmd_ready) begin
                  if (found_ff) begin
                     entry_valid_in[found_idx_ff] = 1'b0;
                  end
                  state_in = ST_CLOSE;
               end
            end else begin
               state_in = ST_CLOSE;
            end
         end

         ST_CLOSE: begin
            cmd.fin = 1'b1;
            if (cmd_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ev_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
         rd_cnt_ff      <= '0;
         res_cnt_ff     <= '0;
         found_ff       <= 1'b0;
         free_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ev_valid_ff    <= ev_valid_in;
         entry_valid_ff <= entry_valid_in;
         rd_cnt_ff      <= rd_cnt_in;
         res_cnt_ff     <= res_cnt_in;
         found_ff       <= found_in;
         free_ff        <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      addr_ff      <= addr_in;
      ev_idx_ff    <= ev_idx_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
   end

endmodule

`default_nettype wire
